// ===== hdl/gwm_pkg.sv =====
// ----------------------------------------------------------------------------
// gwm_pkg
// Shared types and constants of the grid word and cross matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package gwm_pkg;

    localparam int DEF_MAX_LINE   = 256;
    localparam int DEF_COUNT_BITS = 20;

    localparam int CHAR_W    = 8;
    localparam int LINE_W    = 9;
    localparam int TOTAL_W   = 20;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_LETTER_ONE   = 3'd0;
    localparam logic [2:0] REG_LETTER_TWO   = 3'd1;
    localparam logic [2:0] REG_LETTER_THREE = 3'd2;
    localparam logic [2:0] REG_LETTER_FOUR  = 3'd3;
    localparam logic [2:0] REG_LINE_LENGTH  = 3'd4;

    localparam logic [CHAR_W-1:0] LETTER_ONE_RST   = 8'd88;
    localparam logic [CHAR_W-1:0] LETTER_TWO_RST   = 8'd77;
    localparam logic [CHAR_W-1:0] LETTER_THREE_RST = 8'd65;
    localparam logic [CHAR_W-1:0] LETTER_FOUR_RST  = 8'd83;
    localparam logic [LINE_W-1:0] LINE_LENGTH_RST  = 9'd140;

    typedef struct packed {
        logic [CHAR_W-1:0] one;
        logic [CHAR_W-1:0] two;
        logic [CHAR_W-1:0] three;
        logic [CHAR_W-1:0] four;
    } letters_t;

    // Per-character control handed from the column tracker to the core.
    typedef struct packed {
        logic       last;
        logic [1:0] rows;
    } item_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/grid_word_and_cross_matcher.sv =====
// ----------------------------------------------------------------------------
// grid_word_and_cross_matcher
// Eight-direction word search and cross counter over a streamed grid.
// ----------------------------------------------------------------------------
// Characters enter on the s_ channel in raster order, one per transfer, with
// s_tlast on the final character of the grid. Unless stalled, the block
// takes one character per clock cycle; the line buffer is a single memory,
// one word per column, read and written back once per character, with the
// written word forwarded when two neighboring characters share a column
// (a one-character row). On the last character one result transfer leaves on
// the m_ channel with the word and cross counts from registered totals. The
// counts saturate and then restart at zero for the next grid; the letters
// and line length stay as written on the APB port. While a result waits,
// characters are still taken; a further last character is taken but then
// holds off the input until the receiver takes the waiting result.
// Reset restores the register defaults and clears the column, row and count
// state. The line buffer is not cleared: each entry that feeds a match is
// written before it is read while the line length stays unchanged in a grid.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_word_and_cross_matcher import gwm_pkg::*; #(
    parameter int MAX_LINE   = DEF_MAX_LINE,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // tdata: [7:0] cell_char
    input  wire logic [7:0]            s_tdata,
    input  wire logic                  s_tlast,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // tdata: [19:0] word_total, [39:20] cross_total
    output logic      [39:0]           m_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int CW = $clog2(MAX_LINE);

    letters_t           letters;
    logic [LINE_W-1:0]  line_length;
    logic [CW-1:0]      cur_col;
    item_ctl_t          cur_ctl;
    logic               stall;
    logic               in_accept;
    logic [TOTAL_W-1:0] word_total;
    logic [TOTAL_W-1:0] cross_total;

    assign s_tready  = !stall;
    assign in_accept = s_tvalid && s_tready;

    gwm_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .letters     (letters),
        .line_length (line_length)
    );

    gwm_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .in_last     (s_tlast),
        .line_length (line_length),
        .cur_col     (cur_col),
        .cur_ctl     (cur_ctl)
    );

    gwm_core #(
        .MAX_LINE   (MAX_LINE),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_char   (s_tdata),
        .in_col    (cur_col),
        .in_ctl    (cur_ctl),
        .letters   (letters),
        .out_ready (m_tready),
        .stall     (stall),
        .out_valid (m_tvalid),
        .out_word  (word_total),
        .out_cross (cross_total)
    );

    assign m_tdata = {cross_total, word_total};

endmodule

`default_nettype wire

// ===== hdl/gwm_cfg.sv =====
// ----------------------------------------------------------------------------
// gwm_cfg
// APB register file: the four word letters and the grid line length.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_cfg import gwm_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output letters_t                   letters,
    output logic      [LINE_W-1:0]     line_length
);

    letters_t          letters_reg;
    logic [LINE_W-1:0] line_length_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            letters_reg.one   <= LETTER_ONE_RST;
            letters_reg.two   <= LETTER_TWO_RST;
            letters_reg.three <= LETTER_THREE_RST;
            letters_reg.four  <= LETTER_FOUR_RST;
            line_length_reg   <= LINE_LENGTH_RST;
        end else if (wr_en) begin
            unique case (paddr[4:2])
                REG_LETTER_ONE:   letters_reg.one   <= pwdata[CHAR_W-1:0];
                REG_LETTER_TWO:   letters_reg.two   <= pwdata[CHAR_W-1:0];
                REG_LETTER_THREE: letters_reg.three <= pwdata[CHAR_W-1:0];
                REG_LETTER_FOUR:  letters_reg.four  <= pwdata[CHAR_W-1:0];
                REG_LINE_LENGTH:  line_length_reg   <= pwdata[LINE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_LETTER_ONE:   prdata = APB_DATA_W'(letters_reg.one);
            REG_LETTER_TWO:   prdata = APB_DATA_W'(letters_reg.two);
            REG_LETTER_THREE: prdata = APB_DATA_W'(letters_reg.three);
            REG_LETTER_FOUR:  prdata = APB_DATA_W'(letters_reg.four);
            REG_LINE_LENGTH:  prdata = APB_DATA_W'(line_length_reg);
            default:          prdata = '0;
        endcase
    end

    assign letters     = letters_reg;
    assign line_length = line_length_reg;

endmodule

`default_nettype wire

// ===== hdl/gwm_front.sv =====
// ----------------------------------------------------------------------------
// gwm_front
// Column and row tracker: gives each accepted character its column (also the
// line buffer address) and the number of complete rows above it, up to three.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_front import gwm_pkg::*; #(
    parameter int MAX_LINE = DEF_MAX_LINE,
    localparam int CW = $clog2(MAX_LINE),
    localparam int LW = $clog2(MAX_LINE + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_accept,
    input  wire logic              in_last,
    input  wire logic [LINE_W-1:0] line_length,
    output logic      [CW-1:0]     cur_col,
    output item_ctl_t              cur_ctl
);

    localparam int EW = (LW > LINE_W) ? LW : LINE_W;

    logic [CW-1:0] col_reg, col_next;
    logic [1:0]    rows_reg, rows_next;
    logic [EW-1:0] len_ext;
    logic [LW-1:0] len;
    logic [LW-1:0] col_start;
    logic [LW-1:0] col_inc;
    logic [1:0]    rows_start;

    always_comb begin
        len_ext = EW'(line_length);
        if (len_ext == '0) begin
            len_ext = EW'(1);
        end else if (len_ext > EW'(MAX_LINE)) begin
            len_ext = EW'(MAX_LINE);
        end
        len = len_ext[LW-1:0];
    end

    // A stored column at or past the line end (after the length shrank)
    // starts a new row before the character is placed.
    always_comb begin
        if (LW'(col_reg) >= len) begin
            col_start  = '0;
            rows_start = (rows_reg == 2'd3) ? rows_reg : rows_reg + 2'd1;
        end else begin
            col_start  = LW'(col_reg);
            rows_start = rows_reg;
        end
        col_inc = col_start + LW'(1);
        if (col_inc >= len) begin
            col_next  = '0;
            rows_next = (rows_start == 2'd3) ? rows_start : rows_start + 2'd1;
        end else begin
            col_next  = col_inc[CW-1:0];
            rows_next = rows_start;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            rows_reg <= '0;
        end else if (in_accept) begin
            if (in_last) begin
                col_reg  <= '0;
                rows_reg <= '0;
            end else begin
                col_reg  <= col_next;
                rows_reg <= rows_next;
            end
        end
    end

    assign cur_col      = col_start[CW-1:0];
    assign cur_ctl.last = in_last;
    assign cur_ctl.rows = rows_start;

endmodule

`default_nettype wire

// ===== hdl/gwm_core.sv =====
// ----------------------------------------------------------------------------
// gwm_core
// Line buffer memory, 4x4 window and match counting. One memory word holds
// the three stored rows of one column; each character reads its column,
// shifts it up by one row and writes it back.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_core import gwm_pkg::*; #(
    parameter int MAX_LINE   = DEF_MAX_LINE,
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    localparam int CW = $clog2(MAX_LINE)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_accept,
    input  wire logic [CHAR_W-1:0]  in_char,
    input  wire logic [CW-1:0]      in_col,
    input  wire item_ctl_t          in_ctl,
    input  wire letters_t           letters,
    input  wire logic               out_ready,
    output logic                    stall,
    output logic                    out_valid,
    output logic      [TOTAL_W-1:0] out_word,
    output logic      [TOTAL_W-1:0] out_cross
);

    localparam int MW = 3 * CHAR_W;

    // Line buffer: bits [7:0] oldest row, [15:8] middle row, [23:16] newest.
    logic [MW-1:0] line_mem [MAX_LINE];
    logic [MW-1:0] rdata_reg;

    logic              p_valid_reg;
    logic [CHAR_W-1:0] p_char_reg;
    logic [CW-1:0]     p_col_reg;
    item_ctl_t         p_ctl_reg;
    logic              fwd_reg;
    logic [MW-1:0]     wfwd_reg;

    logic [CHAR_W-1:0] hist_reg [4][3];
    logic [CHAR_W-1:0] win [4][4];

    logic [COUNT_BITS-1:0] word_tally_reg, word_tally_next;
    logic [COUNT_BITS-1:0] cross_tally_reg, cross_tally_next;
    logic                  out_valid_reg;
    logic [TOTAL_W-1:0]    out_word_reg, out_cross_reg;

    logic [MW-1:0] col_data;
    logic [MW-1:0] wdata;
    logic          proc;
    logic [3:0]    words;
    logic          cross_hit;
    logic [2:0]    n_two;
    logic          all_corners;
    logic          col_ge2, col_ge3, rows_ge2, rows_ge3;

    function automatic logic [1:0] word4(
        input letters_t          lt,
        input logic [CHAR_W-1:0] a,
        input logic [CHAR_W-1:0] b,
        input logic [CHAR_W-1:0] c,
        input logic [CHAR_W-1:0] d
    );
        logic fwd_hit, rev_hit;
        fwd_hit = (a == lt.one) && (b == lt.two) && (c == lt.three) && (d == lt.four);
        rev_hit = (d == lt.one) && (c == lt.two) && (b == lt.three) && (a == lt.four);
        return {1'b0, fwd_hit} + {1'b0, rev_hit};
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_add(
        input logic [COUNT_BITS-1:0] t,
        input logic [3:0]            n
    );
        logic [COUNT_BITS:0] s;
        s = {1'b0, t} + (COUNT_BITS + 1)'(n);
        return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
    endfunction

    // A finished frame cannot leave while the previous result still waits.
    assign stall = p_valid_reg && p_ctl_reg.last && out_valid_reg && !out_ready;
    assign proc  = p_valid_reg && !stall;

    // The memory is read at the same edge that the item ahead writes back;
    // when both hit one column, the written word is taken instead.
    assign col_data = fwd_reg ? wfwd_reg : rdata_reg;
    assign wdata    = {p_char_reg, col_data[MW-1:2*CHAR_W], col_data[2*CHAR_W-1:CHAR_W]};

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 3; j++) begin
                win[i][j] = hist_reg[i][j];
            end
        end
        win[0][3] = col_data[CHAR_W-1:0];
        win[1][3] = col_data[2*CHAR_W-1:CHAR_W];
        win[2][3] = col_data[MW-1:2*CHAR_W];
        win[3][3] = p_char_reg;
    end

    assign col_ge2  = (p_col_reg >= CW'(2));
    assign col_ge3  = (p_col_reg >= CW'(3));
    assign rows_ge2 = (p_ctl_reg.rows >= 2'd2);
    assign rows_ge3 = (p_ctl_reg.rows == 2'd3);

    always_comb begin
        words = '0;
        if (col_ge3) begin
            words = words + 4'(word4(letters, win[3][0], win[3][1], win[3][2], win[3][3]));
        end
        if (rows_ge3) begin
            words = words + 4'(word4(letters, win[0][3], win[1][3], win[2][3], win[3][3]));
        end
        if (col_ge3 && rows_ge3) begin
            words = words + 4'(word4(letters, win[0][0], win[1][1], win[2][2], win[3][3]));
            words = words + 4'(word4(letters, win[0][3], win[1][2], win[2][1], win[3][0]));
        end
    end

    // A corner equal to both corner letters counts as letter_two.
    always_comb begin
        n_two = 3'(win[1][1] == letters.two) + 3'(win[1][3] == letters.two)
              + 3'(win[3][1] == letters.two) + 3'(win[3][3] == letters.two);
        all_corners = ((win[1][1] == letters.two) || (win[1][1] == letters.four))
                   && ((win[1][3] == letters.two) || (win[1][3] == letters.four))
                   && ((win[3][1] == letters.two) || (win[3][1] == letters.four))
                   && ((win[3][3] == letters.two) || (win[3][3] == letters.four));
        cross_hit = col_ge2 && rows_ge2 && (win[2][2] == letters.three)
                 && all_corners && (n_two == 3'd2) && (win[1][1] != win[3][3]);
    end

    assign word_tally_next  = sat_add(word_tally_reg, words);
    assign cross_tally_next = sat_add(cross_tally_reg, {3'b000, cross_hit});

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            rdata_reg <= line_mem[in_col];
        end
        if (proc) begin
            line_mem[p_col_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            p_char_reg <= in_char;
            p_col_reg  <= in_col;
            p_ctl_reg  <= in_ctl;
            fwd_reg    <= p_valid_reg && (p_col_reg == in_col);
        end
        if (proc) begin
            wfwd_reg <= wdata;
            for (int i = 0; i < 4; i++) begin
                hist_reg[i][0] <= win[i][1];
                hist_reg[i][1] <= win[i][2];
                hist_reg[i][2] <= win[i][3];
            end
            if (p_ctl_reg.last) begin
                out_word_reg  <= TOTAL_W'(word_tally_next);
                out_cross_reg <= TOTAL_W'(cross_tally_next);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            word_tally_reg  <= '0;
            cross_tally_reg <= '0;
        end else begin
            if (in_accept) begin
                p_valid_reg <= 1'b1;
            end else if (proc) begin
                p_valid_reg <= 1'b0;
            end
            if (proc && p_ctl_reg.last) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (proc) begin
                word_tally_reg  <= p_ctl_reg.last ? '0 : word_tally_next;
                cross_tally_reg <= p_ctl_reg.last ? '0 : cross_tally_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_cross = out_cross_reg;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grid word and cross matcher.
// ----------------------------------------------------------------------------
// Grids stream into the block one character per transfer. A scoreboard keeps
// its own line buffers, window and tallies, and it works out the word and
// cross totals that each last character should produce. Every result
// transfer is compared field by field with the oldest expected totals.
// A few hand-built grids come first: the word both ways, one cross, and a
// line length cut short in the middle of a grid. Random grids follow, each
// batch under a different letter set and line length. A short grid of one
// repeated letter closes the run, where every reading matches both ways.
// ----------------------------------------------------------------------------

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gwm_pkg::*;

    localparam int unsigned COUNT_MAX        = (1 << DEF_COUNT_BITS) - 1;
    localparam int unsigned CYCLE_LIMIT      = 100_000;
    localparam int unsigned RANDOM_ITEMS     = 700;
    localparam int unsigned PHASE_ITEMS      = 50;
    localparam int unsigned SETTLE_CYCLES    = 4;

    typedef struct packed {
        logic [TOTAL_W-1:0] cross_total;
        logic [TOTAL_W-1:0] word_total;
    } totals_t;

    class match_scoreboard;
        typedef enum int {CORNER_OTHER, CORNER_TWO, CORNER_FOUR} corner_e;

        letters_t          letters;
        logic [LINE_W-1:0] line_len;
        logic [CHAR_W-1:0] row_buf [3][DEF_MAX_LINE];
        logic [CHAR_W-1:0] win [4][4];
        int unsigned       col;
        int unsigned       rows_seen;
        int unsigned       word_count;
        int unsigned       cross_count;
        totals_t           expected_totals [$];
        int unsigned       totals_checked;
        int unsigned       errors;

        function new();
            letters = '{LETTER_ONE_RST, LETTER_TWO_RST, LETTER_THREE_RST, LETTER_FOUR_RST};
            line_len = LINE_LENGTH_RST;
            foreach (row_buf[r, k]) row_buf[r][k] = '0;
            clear_frame();
            totals_checked = 0;
            errors = 0;
        endfunction

        function void clear_frame();
            foreach (win[r, k]) win[r][k] = '0;
            col = 0;
            rows_seen = 0;
            word_count = 0;
            cross_count = 0;
        endfunction

        function void write_reg(logic [2:0] index, logic [APB_DATA_W-1:0] value);
            case (index)
                REG_LETTER_ONE:   letters.one   = value[CHAR_W-1:0];
                REG_LETTER_TWO:   letters.two   = value[CHAR_W-1:0];
                REG_LETTER_THREE: letters.three = value[CHAR_W-1:0];
                REG_LETTER_FOUR:  letters.four  = value[CHAR_W-1:0];
                REG_LINE_LENGTH:  line_len      = value[LINE_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned row_span();
            if (line_len == 0) return 1;
            if (line_len > DEF_MAX_LINE) return DEF_MAX_LINE;
            return line_len;
        endfunction

        // A word that reads the same both ways is counted twice.
        function int unsigned word_hits(logic [CHAR_W-1:0] a, b, c, d);
            int unsigned n;
            n = 0;
            if (a == letters.one && b == letters.two && c == letters.three && d == letters.four)
                n++;
            if (d == letters.one && c == letters.two && b == letters.three && a == letters.four)
                n++;
            return n;
        endfunction

        // A corner that equals both corner letters is taken as the second letter.
        function corner_e corner_kind(logic [CHAR_W-1:0] v);
            if (v == letters.two) return CORNER_TWO;
            if (v == letters.four) return CORNER_FOUR;
            return CORNER_OTHER;
        endfunction

        function void advance_row();
            col = 0;
            if (rows_seen < 3) rows_seen++;
        endfunction

        function void take_char(logic [CHAR_W-1:0] ch, logic last);
            int unsigned span;
            int unsigned c;
            int unsigned hits;
            int unsigned r;
            int unsigned kinds [3];
            totals_t     due;
            span = row_span();
            // A line length cut below the current column starts a new row.
            if (col >= span) advance_row();
            c = col;

            for (r = 0; r < 4; r++) begin
                win[r][0] = win[r][1];
                win[r][1] = win[r][2];
                win[r][2] = win[r][3];
            end
            win[0][3] = row_buf[0][c];
            win[1][3] = row_buf[1][c];
            win[2][3] = row_buf[2][c];
            win[3][3] = ch;
            row_buf[0][c] = win[1][3];
            row_buf[1][c] = win[2][3];
            row_buf[2][c] = ch;

            // Cells left of column 0 or above row 0 never take part.
            hits = 0;
            if (c >= 3)
                hits += word_hits(win[3][0], win[3][1], win[3][2], win[3][3]);
            if (rows_seen >= 3)
                hits += word_hits(win[0][3], win[1][3], win[2][3], win[3][3]);
            if (c >= 3 && rows_seen >= 3) begin
                hits += word_hits(win[0][0], win[1][1], win[2][2], win[3][3]);
                hits += word_hits(win[0][3], win[1][2], win[2][1], win[3][0]);
            end
            word_count = (word_count + hits > COUNT_MAX) ? COUNT_MAX : word_count + hits;

            // The cross is centred one row up and one column left of the newest cell.
            if (c >= 2 && rows_seen >= 2 && win[2][2] == letters.three) begin
                kinds = '{0, 0, 0};
                kinds[corner_kind(win[1][1])]++;
                kinds[corner_kind(win[1][3])]++;
                kinds[corner_kind(win[3][1])]++;
                kinds[corner_kind(win[3][3])]++;
                if (kinds[CORNER_OTHER] == 0 && kinds[CORNER_TWO] == 2 &&
                    kinds[CORNER_FOUR] == 2 && win[1][1] != win[3][3] &&
                    cross_count < COUNT_MAX)
                    cross_count++;
            end

            col = c + 1;
            if (col >= span) advance_row();

            if (last) begin
                due.word_total  = word_count[TOTAL_W-1:0];
                due.cross_total = cross_count[TOTAL_W-1:0];
                expected_totals.push_back(due);
                clear_frame();
            end
        endfunction

        function void check_totals(totals_t got);
            totals_t want;
            totals_checked++;
            if (expected_totals.size() == 0) begin
                $error("result transfer with no totals expected: word_total %0d, cross_total %0d",
                       got.word_total, got.cross_total);
                errors++;
            end else begin
                want = expected_totals.pop_front();
                if (got.word_total !== want.word_total) begin
                    $error("word_total: expected %0d, got %0d", want.word_total, got.word_total);
                    errors++;
                end
                if (got.cross_total !== want.cross_total) begin
                    $error("cross_total: expected %0d, got %0d",
                           want.cross_total, got.cross_total);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic [7:0]            s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [39:0]           m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    match_scoreboard sb;
    int unsigned     send_idle_pct = 0;
    int unsigned     recv_idle_pct = 0;
    int unsigned     cycle_count   = 0;

    grid_word_and_cross_matcher u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_totals(m_tdata);
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.take_char(ch, last);
        @(negedge aclk);
    endtask

    task automatic send_run(input logic [CHAR_W-1:0] chars [$], input logic ends_frame);
        foreach (chars[i]) send_char(chars[i], ends_frame && i == chars.size() - 1);
    endtask

    // Holds the sender off until every expected result has arrived and the
    // pipeline has had time to empty.
    task automatic drain_totals();
        s_tvalid <= 1'b0;
        while (sb.expected_totals.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // psel stays high from one write to the next; bus_release ends a batch.
    task automatic reg_write(input logic [2:0] index, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(index, value);
        @(negedge aclk);
    endtask

    task automatic bus_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_setting(input letters_t pick, input logic [LINE_W-1:0] len);
        reg_write(REG_LETTER_ONE,   APB_DATA_W'(pick.one));
        reg_write(REG_LETTER_TWO,   APB_DATA_W'(pick.two));
        reg_write(REG_LETTER_THREE, APB_DATA_W'(pick.three));
        reg_write(REG_LETTER_FOUR,  APB_DATA_W'(pick.four));
        reg_write(REG_LINE_LENGTH,  APB_DATA_W'(len));
        bus_release();
    endtask

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[grid_word_and_cross_matcher] ERROR");
        $finish;
    end

    initial begin
        logic [CHAR_W-1:0] run [$];
        logic [CHAR_W-1:0] ch;
        logic [LINE_W-1:0] phase_lengths [9];
        logic [LINE_W-1:0] len;
        letters_t          pick;
        letters_t          std_letters;
        int unsigned       phase;
        int unsigned       phase_items;
        int unsigned       sent_items;
        int unsigned       span;
        int unsigned       count;
        int unsigned       k;

        sb = new();
        std_letters = '{LETTER_ONE_RST, LETTER_TWO_RST, LETTER_THREE_RST, LETTER_FOUR_RST};
        send_idle_pct = 31;
        recv_idle_pct = 59;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset defaults: the word forward and reversed in one row, framed
        // by the lowest and highest character codes.
        run = '{8'h00, LETTER_ONE_RST, LETTER_TWO_RST, LETTER_THREE_RST, LETTER_FOUR_RST,
                LETTER_THREE_RST, LETTER_TWO_RST, LETTER_ONE_RST, 8'hFF};
        send_run(run, 1'b1);
        drain_totals();

        // One cross on a three by three grid.
        apply_setting(std_letters, 9'd3);
        run = '{LETTER_TWO_RST, 8'hFF, LETTER_FOUR_RST,
                8'h00, LETTER_THREE_RST, 8'hFF,
                LETTER_TWO_RST, 8'h00, LETTER_FOUR_RST};
        send_run(run, 1'b1);
        drain_totals();

        // The line length shrinks below the current column mid-grid.
        apply_setting(std_letters, 9'd8);
        run = '{LETTER_ONE_RST, LETTER_TWO_RST, LETTER_THREE_RST, LETTER_FOUR_RST,
                LETTER_ONE_RST, LETTER_TWO_RST};
        send_run(run, 1'b0);
        drain_totals();
        reg_write(REG_LINE_LENGTH, APB_DATA_W'(9'd2));
        bus_release();
        run = '{LETTER_THREE_RST, LETTER_FOUR_RST};
        send_run(run, 1'b1);
        drain_totals();

        // Zero and lengths past the line buffer size are folded by the block.
        phase_lengths = '{9'd4, 9'd1, 9'd0, 9'd5, 9'd256, 9'd3, 9'd511, 9'd2, 9'd7};
        phase = 0;
        sent_items = 0;
        while (phase < 9 || sent_items < RANDOM_ITEMS) begin
            if (phase == 3) begin
                send_idle_pct = 59;
                recv_idle_pct = 31;
            end
            if (phase == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick.one   = CHAR_W'($urandom_range(0, 255));
            pick.two   = CHAR_W'($urandom_range(0, 255));
            pick.three = CHAR_W'($urandom_range(0, 255));
            pick.four  = CHAR_W'($urandom_range(0, 255));
            case (phase)
                0: pick = std_letters;
                1: pick = '{8'h00, 8'h01, 8'hFE, 8'hFF};
                2: begin
                    pick.four  = pick.one;
                    pick.three = pick.two;
                end
                3: pick.four = pick.two;
                default: ;
            endcase
            len = (phase < 9) ? phase_lengths[phase] : LINE_W'($urandom_range(1, 12));
            apply_setting(pick, len);
            span = sb.row_span();

            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                count = ($urandom_range(0, 9) == 0) ? 1 :
                        (span > 16) ? $urandom_range(span / 2, span + 40) :
                        $urandom_range(1, 7) * span + $urandom_range(0, span - 1);
                // Mostly the four letters, so that words and crosses form.
                for (k = 0; k < count; k++) begin
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3:     ch = pick.one;
                        4, 5, 6, 7:     ch = pick.two;
                        8, 9, 10, 11:   ch = pick.three;
                        12, 13, 14, 15: ch = pick.four;
                        default:        ch = CHAR_W'($urandom_range(0, 255));
                    endcase
                    send_char(ch, k == count - 1);
                end
                phase_items += count;
                if ($urandom_range(0, 3) == 0) drain_totals();
            end
            sent_items += phase_items;
            drain_totals();
            phase++;
        end

        // All letters equal: every reading matches both ways.
        pick = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
        apply_setting(pick, 9'd256);
        for (k = 0; k < 8; k++) send_char(8'hFF, k == 7);
        drain_totals();

        if (sb.errors == 0) begin
            $display("[grid_word_and_cross_matcher] OK");
        end else begin
            $display("[grid_word_and_cross_matcher] ERROR");
        end
        $finish;
    end

endmodule
